### rtl/ghweb_pkg.sv
package ghweb_pkg;

    typedef struct packed {
        logic [62:0] hit_time;
        logic signed [23:0] hit_energy;
        logic [23:0] hit_tot;
        logic [15:0] hit_channel;
        logic [7:0]  fiber_index;
        logic [1:0]  plane;
    } t_hit;

    typedef struct packed {
        logic [62:0] gate_time;
        logic [1:0]  out_plane;
        logic [62:0] out_time;
        logic signed [23:0] out_energy;
        logic [23:0] out_tot;
        logic [15:0] out_channel;
        logic [7:0]  out_fiber;
        logic        has_hit;
        logic        overflow;
        logic        last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_REQ,
        ST_SCAN_CHK,
        ST_PICK_INIT,
        ST_PICK_REQ,
        ST_PICK_WAIT,
        ST_PICK_CHK,
        ST_EMIT_REQ,
        ST_EMIT_WAIT,
        ST_EMIT,
        ST_EMPTY,
        ST_STORE
    } t_state;

    localparam logic [1:0] REG_GATE_CHANNEL = 2'd0;
    localparam logic [1:0] REG_RISE_LEVEL   = 2'd1;
    localparam logic [1:0] REG_WIN_LO       = 2'd2;
    localparam logic [1:0] REG_WIN_HI       = 2'd3;

    localparam int HIT_W = $bits(t_hit);

endpackage

### rtl/gated_hit_window_event_builder_unit.sv
// Gated hit-window event builder. Every accepted hit is written to a history ring of
// HISTORY_DEPTH entries. A hit on the gate channel whose energy equals rise_level starts
// a backward scan over earlier hits; hits whose time minus gate time lies in
// [win_lo, win_hi] on planes 0..PLANES-1 are collected (up to MAX_EVENT_HITS, overflow
// flagged beyond). The event goes out plane by plane, each plane by tot descending with
// ties in collection order; an event with nothing collected gives one empty transfer.
// A plain hit is accepted, then stored. A gate hit scans the history, then sorts and
// emits the collected hits, with output stalls holding each transfer; the sort makes one
// selection pass per collected hit plus one per plane skipped over (at most PLANES-1).
// All work goes through the single history read port, and each selection pass reads
// the collected tot values one at a time (slot read, history read, compare). No hit is
// accepted while an event is in progress.
module gated_hit_window_event_builder_unit
    import ghweb_pkg::*;
#(
    parameter int HISTORY_DEPTH  = 1024,
    parameter int MAX_EVENT_HITS = 64,
    parameter int PLANES         = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [24:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ghweb_pkg::t_hit      i_hit,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ghweb_pkg::t_result   o_result
);
    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int SW  = (MAX_EVENT_HITS > 1) ? $clog2(MAX_EVENT_HITS) : 1;
    localparam int CW  = $clog2(MAX_EVENT_HITS + 1);
    localparam int FW  = $clog2(HISTORY_DEPTH + 1);

    // configuration
    logic [15:0] r_gate_channel;
    logic [23:0] r_rise_level;
    logic signed [24:0] r_win_lo, r_win_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_channel <= 16'd4128;
            r_rise_level   <= 24'd1280;
            r_win_lo       <= -25'sd295000;
            r_win_hi       <= -25'sd270000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GATE_CHANNEL: r_gate_channel <= i_cfg_data[15:0];
                REG_RISE_LEVEL:   r_rise_level   <= i_cfg_data[23:0];
                REG_WIN_LO:       r_win_lo       <= i_cfg_data;
                REG_WIN_HI:       r_win_hi       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control and data registers
    t_state r_state, n_state;
    t_hit   r_hit;
    logic [AW-1:0] r_wp, r_idx;
    logic [FW-1:0] r_fill, r_left;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [1:0]    r_plane;
    logic [SW-1:0] r_i;
    logic [CW-1:0] r_emitted;
    logic          r_found;
    logic [SW-1:0] r_best;
    logic [23:0]   r_best_tot;
    logic [MAX_EVENT_HITS-1:0] r_done;

    // history ring (one write, one read port)
    logic          hist_we;
    logic [AW-1:0] hist_raddr;
    t_hit          hist_rd;
    logic [HIT_W-1:0] hist_rd_bits;
    assign hist_rd = t_hit'(hist_rd_bits);

    ghweb_ram #(.WIDTH(HIT_W), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(r_wp), .i_wdata(r_hit),
        .i_raddr(hist_raddr), .o_rdata(hist_rd_bits)
    );

    // slot list of collected history indices
    logic          slot_we;
    logic [SW-1:0] slot_waddr, slot_raddr;
    logic [AW-1:0] slot_rd;

    ghweb_ram #(.WIDTH(AW), .DEPTH(MAX_EVENT_HITS)) u_slots (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(r_idx),
        .i_raddr(slot_raddr), .o_rdata(slot_rd)
    );

    // shared window compare on the fetched entry
    logic signed [63:0] dt;
    logic above_hi, below_lo;
    assign dt = $signed({1'b0, hist_rd.hit_time}) - $signed({1'b0, r_hit.hit_time});
    assign above_hi = dt > 64'(r_win_hi);
    assign below_lo = dt < 64'(r_win_lo);

    logic is_gate;
    assign is_gate = (i_hit.hit_channel == r_gate_channel)
                  && (i_hit.hit_energy == r_rise_level);

    logic [AW-1:0] prev_idx;
    assign prev_idx = (r_idx == '0) ? AW'(HISTORY_DEPTH - 1) : r_idx - 1'b1;

    logic [SW-1:0] last_slot;
    assign last_slot = SW'(r_count - 1'b1);

    // pick step: history data in PICK_CHK belongs to slot r_i
    logic cand_ok;
    assign cand_ok = hist_rd.plane == r_plane && !r_done[r_i]
                     && (!r_found || hist_rd.hit_tot > r_best_tot);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (is_gate) n_state = (r_fill == '0) ? ST_EMPTY : ST_SCAN_REQ;
                    else         n_state = ST_STORE;
                end
            end
            ST_SCAN_REQ: n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (!above_hi && below_lo) begin
                    n_state = (r_count == '0) ? ST_EMPTY : ST_PICK_INIT;
                end else if (r_left == FW'(1)) begin
                    n_state = (r_count == '0 && (above_hi ||
                               hist_rd.plane >= 2'(PLANES))) ? ST_EMPTY : ST_PICK_INIT;
                end else begin
                    n_state = ST_SCAN_REQ;
                end
            end
            ST_PICK_INIT: n_state = ST_PICK_REQ;
            ST_PICK_REQ:  n_state = ST_PICK_WAIT;
            ST_PICK_WAIT: n_state = ST_PICK_CHK;
            ST_PICK_CHK: begin
                if (r_i != last_slot)          n_state = ST_PICK_REQ;
                else if (r_found || cand_ok)   n_state = ST_EMIT_REQ;
                else if (r_plane == 2'(PLANES - 1)) n_state = ST_STORE;
                else                           n_state = ST_PICK_INIT;
            end
            ST_EMIT_REQ:  n_state = ST_EMIT_WAIT;
            ST_EMIT_WAIT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_ready) n_state = (r_emitted + 1'b1 == r_count) ? ST_STORE : ST_PICK_INIT;
            end
            ST_EMPTY: if (i_ready) n_state = ST_STORE;
            ST_STORE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_ready    = 1'b0;
        o_valid    = 1'b0;
        hist_we    = 1'b0;
        hist_raddr = prev_idx;
        slot_we    = 1'b0;
        slot_waddr = SW'(r_count);
        slot_raddr = r_i;
        o_result   = '0;
        o_result.gate_time = r_hit.hit_time;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_SCAN_REQ: hist_raddr = prev_idx;
            ST_SCAN_CHK: begin
                slot_we = !above_hi && !below_lo && hist_rd.plane < 2'(PLANES)
                          && r_count < CW'(MAX_EVENT_HITS);
            end
            ST_PICK_REQ: slot_raddr = r_i;
            ST_PICK_WAIT: hist_raddr = slot_rd;
            ST_EMIT_REQ: slot_raddr = r_best;
            ST_EMIT_WAIT: begin
                slot_raddr = r_best;
                hist_raddr = slot_rd;
            end
            ST_EMIT: begin
                // keep both reads on the selected hit while the transfer waits
                slot_raddr = r_best;
                hist_raddr = slot_rd;
                o_valid = 1'b1;
                o_result.out_plane   = r_plane;
                o_result.out_time    = hist_rd.hit_time;
                o_result.out_energy  = hist_rd.hit_energy;
                o_result.out_tot     = hist_rd.hit_tot;
                o_result.out_channel = hist_rd.hit_channel;
                o_result.out_fiber   = hist_rd.fiber_index;
                o_result.has_hit     = 1'b1;
                o_result.overflow    = r_ovf;
                o_result.last        = (r_emitted + 1'b1 == r_count);
            end
            ST_EMPTY: begin
                o_valid = 1'b1;
                o_result.last = 1'b1;
            end
            ST_STORE: hist_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_STORE) begin
                r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != FW'(HISTORY_DEPTH)) r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_hit     <= i_hit;
                r_idx     <= r_wp;
                r_left    <= r_fill;
                r_count   <= '0;
                r_ovf     <= 1'b0;
                r_plane   <= '0;
                r_emitted <= '0;
                r_done    <= '0;
            end
            ST_SCAN_REQ: r_idx <= prev_idx;
            ST_SCAN_CHK: begin
                r_left <= r_left - 1'b1;
                if (!above_hi && !below_lo && hist_rd.plane < 2'(PLANES)) begin
                    if (r_count < CW'(MAX_EVENT_HITS)) r_count <= r_count + 1'b1;
                    else                               r_ovf   <= 1'b1;
                end
            end
            ST_PICK_INIT: begin
                r_i     <= '0;
                r_found <= 1'b0;
            end
            ST_PICK_CHK: begin
                if (r_i != last_slot) r_i <= r_i + 1'b1;
                else if (!r_found && !cand_ok && r_plane != 2'(PLANES - 1))
                    r_plane <= r_plane + 1'b1;
                if (cand_ok) begin
                    r_found    <= 1'b1;
                    r_best     <= r_i;
                    r_best_tot <= hist_rd.hit_tot;
                end
            end
            ST_EMIT: if (i_ready) begin
                r_emitted      <= r_emitted + 1'b1;
                r_done[r_best] <= 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EVENT_HITS)) else $error("count above cap");
    a_store_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |=> r_state == ST_IDLE) else $error("store not followed by idle");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result changed while waiting");
`endif
endmodule

### rtl/ghweb_ram.sv
module ghweb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
